### sv/hcp_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_pkg: shared types and constants of the Hermite curve point generator
// Widths of the coordinate fields, the per-segment coefficient record that
// travels from the front end through the queue to the evaluator, and the
// queue control records.
// ----------------------------------------------------------------------------
package hcp_pkg;

  localparam int STEPS_DEF   = 10;  // default number of line-to steps per segment
  localparam int QUEUE_DEPTH = 2;   // default depth of the segment queue

  localparam int COORD_W = 10;  // input coordinate width
  localparam int POINT_W = 12;  // output coordinate width (signed)
  localparam int TAN_W   = 11;  // tangent width (signed)
  localparam int LIN_W   = 14;  // width of the linear coefficient combinations
  localparam int ACC_W   = 32;  // forward difference accumulators (signed)
  localparam int MAG_W   = 24;  // magnitude of a scaled coordinate before division

  typedef logic [COORD_W-1:0]        coord_t;
  typedef logic signed [POINT_W-1:0] point_t;

  // Per-axis data handed to the evaluator. a_lin and b_lin are the cubic and
  // quadratic polynomial coefficients before scaling by the step count.
  typedef struct packed {
    coord_t                   p0;
    logic signed [TAN_W-1:0]  m0;
    logic signed [LIN_W-1:0]  a_lin;
    logic signed [LIN_W-1:0]  b_lin;
  } axis_coef_t;

  typedef struct packed {
    axis_coef_t x;
    axis_coef_t y;
  } seg_coef_t;

  typedef struct packed {
    logic      valid;
    seg_coef_t data;
  } seg_req_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

### sv/hcp_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_if: channel interfaces of the Hermite curve point generator
// hcp_seg_if carries one curve segment, hcp_pt_if carries one curve point.
// Both use a valid/ready handshake.
// ----------------------------------------------------------------------------
interface hcp_seg_if;
  logic                 valid;
  logic                 ready;
  hcp_pkg::coord_t      start_x;
  hcp_pkg::coord_t      start_y;
  hcp_pkg::coord_t      end_x;
  hcp_pkg::coord_t      end_y;
  hcp_pkg::coord_t      start_handle_x;
  hcp_pkg::coord_t      start_handle_y;
  hcp_pkg::coord_t      end_handle_x;
  hcp_pkg::coord_t      end_handle_y;

  modport source (
    output valid, start_x, start_y, end_x, end_y,
           start_handle_x, start_handle_y, end_handle_x, end_handle_y,
    input  ready
  );
  modport sink (
    input  valid, start_x, start_y, end_x, end_y,
           start_handle_x, start_handle_y, end_handle_x, end_handle_y,
    output ready
  );
endinterface

interface hcp_pt_if;
  logic                 valid;
  logic                 ready;
  hcp_pkg::point_t      point_x;
  hcp_pkg::point_t      point_y;
  logic                 is_move;
  logic                 last_point;

  modport source (
    output valid, point_x, point_y, is_move, last_point,
    input  ready
  );
  modport sink (
    input  valid, point_x, point_y, is_move, last_point,
    output ready
  );
endinterface

### sv/hcp_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_front: segment intake
// Accepts a segment when the queue has room, forms the tangents and the
// linear coefficient combinations of the Hermite polynomial for each axis.
// ----------------------------------------------------------------------------
module hcp_front (
  hcp_seg_if.sink           seg_i,
  input  hcp_pkg::q_stat_t  q_stat_i,
  output hcp_pkg::seg_req_t push_o
);

  // Polynomial in k, scaled by S^3:
  //   k^3 : 2*P0 - 2*P1 + M0 + M1
  //   k^2 : S * (3*(P1 - P0) - 2*M0 - M1)
  //   k   : S^2 * M0
  //   1   : S^3 * P0
  function automatic hcp_pkg::axis_coef_t prep_axis(
    input hcp_pkg::coord_t p0,
    input hcp_pkg::coord_t p1,
    input hcp_pkg::coord_t h0,
    input hcp_pkg::coord_t h1
  );
    logic signed [hcp_pkg::LIN_W-1:0] sp0;
    logic signed [hcp_pkg::LIN_W-1:0] sp1;
    logic signed [hcp_pkg::LIN_W-1:0] m0;
    logic signed [hcp_pkg::LIN_W-1:0] m1;
    logic signed [hcp_pkg::LIN_W-1:0] dp;
    hcp_pkg::axis_coef_t              r;
    sp0     = $signed({{(hcp_pkg::LIN_W-hcp_pkg::COORD_W){1'b0}}, p0});
    sp1     = $signed({{(hcp_pkg::LIN_W-hcp_pkg::COORD_W){1'b0}}, p1});
    m0      = $signed({{(hcp_pkg::LIN_W-hcp_pkg::COORD_W){1'b0}}, h0}) - sp0;
    m1      = $signed({{(hcp_pkg::LIN_W-hcp_pkg::COORD_W){1'b0}}, h1}) - sp1;
    dp      = sp1 - sp0;
    r.p0    = p0;
    r.m0    = m0[hcp_pkg::TAN_W-1:0];
    r.a_lin = (sp0 <<< 1) - (sp1 <<< 1) + m0 + m1;
    r.b_lin = (dp <<< 1) + dp - (m0 <<< 1) - m1;
    return r;
  endfunction

  assign seg_i.ready  = !q_stat_i.full;
  assign push_o.valid = seg_i.valid && !q_stat_i.full;
  assign push_o.data.x = prep_axis(seg_i.start_x, seg_i.end_x,
                                   seg_i.start_handle_x, seg_i.end_handle_x);
  assign push_o.data.y = prep_axis(seg_i.start_y, seg_i.end_y,
                                   seg_i.start_handle_y, seg_i.end_handle_y);

endmodule

### sv/hcp_queue.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_queue: segment queue
// Short first-in first-out queue of prepared segments between the intake and
// the evaluator.
// ----------------------------------------------------------------------------
module hcp_queue #(
  parameter int Depth = hcp_pkg::QUEUE_DEPTH
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcp_pkg::seg_req_t  push_i,
  input  logic               pop_i,
  output hcp_pkg::q_stat_t   stat_o,
  output hcp_pkg::seg_coef_t data_o
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] PtrLast = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] CntFull = CntW'(Depth);

  hcp_pkg::seg_coef_t mem_q [Depth];
  logic [PtrW-1:0]    wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]    rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]    cnt_q, cnt_d;
  logic               push, pop;

  assign push = push_i.valid && (cnt_q != CntFull);
  assign pop  = pop_i && (cnt_q != '0);

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == PtrLast) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == PtrLast) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      cnt_d = cnt_q + 1'b1;
    end else if (pop && !push) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_i.data;
    end
  end

  assign stat_o.full  = (cnt_q == CntFull);
  assign stat_o.empty = (cnt_q == '0);
  assign data_o       = mem_q[rd_ptr_q];

  a_no_push_full : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i.valid && (cnt_q == CntFull) && !pop_i |=> cnt_q == CntFull)
    else $error("queue count changed on a push into a full queue");

  a_cnt_ptr : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cnt_q == '0) |-> (wr_ptr_q == rd_ptr_q))
    else $error("empty queue with differing pointers");

endmodule

### sv/hcp_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hcp_back: curve evaluator
// Steps the scaled Hermite polynomial of each axis by forward differences,
// divides by S^3 with truncation toward zero and registers the points.
// ----------------------------------------------------------------------------
module hcp_back #(
  parameter int Steps = hcp_pkg::STEPS_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcp_pkg::seg_coef_t coef_i,
  input  hcp_pkg::q_stat_t   stat_i,
  output logic               pop_o,
  hcp_pt_if.source           pt_o
);

  localparam int ACC_W  = hcp_pkg::ACC_W;
  localparam int MAG_W  = hcp_pkg::MAG_W;
  localparam int Cube   = Steps * Steps * Steps;
  localparam int Sq     = Steps * Steps;
  localparam int CntW   = $clog2(Steps + 2);
  localparam int Sh     = MAG_W + 1;
  localparam int RecipW = Sh + 1;
  localparam int ProdW  = MAG_W + RecipW;
  localparam longint unsigned RecipVal = (64'd1 << Sh) / Cube;
  localparam logic [RecipW-1:0]       Recip   = RecipW'(RecipVal);
  localparam logic [MAG_W-1:0]        Div     = MAG_W'(Cube);
  localparam logic [CntW-1:0]         CntLast = CntW'(Steps + 1);
  localparam logic signed [ACC_W-1:0] KCube   = ACC_W'(Cube);
  localparam logic signed [ACC_W-1:0] KSq     = ACC_W'(Sq);
  localparam logic signed [ACC_W-1:0] KSteps  = ACC_W'(Steps);

  typedef struct packed {
    logic signed [ACC_W-1:0] f;
    logic signed [ACC_W-1:0] d1;
    logic signed [ACC_W-1:0] d2;
    logic signed [ACC_W-1:0] d3;
  } fd_t;

  // Value and first three forward differences at k = 0.
  function automatic fd_t load_axis(input hcp_pkg::axis_coef_t c);
    logic signed [ACC_W-1:0] a;
    logic signed [ACC_W-1:0] b;
    logic signed [ACC_W-1:0] lin;
    fd_t                     r;
    a    = ACC_W'(c.a_lin);
    b    = ACC_W'(c.b_lin) * KSteps;
    lin  = ACC_W'(c.m0) * KSq;
    r.f  = $signed({{(ACC_W-hcp_pkg::COORD_W){1'b0}}, c.p0}) * KCube;
    r.d1 = a + b + lin;
    r.d2 = (a <<< 2) + (a <<< 1) + (b <<< 1);
    r.d3 = (a <<< 2) + (a <<< 1);
    return r;
  endfunction

  function automatic fd_t step_axis(input fd_t v);
    fd_t r;
    r.f  = v.f + v.d1;
    r.d1 = v.d1 + v.d2;
    r.d2 = v.d2 + v.d3;
    r.d3 = v.d3;
    return r;
  endfunction

  function automatic logic [MAG_W-1:0] mag_of(input logic signed [ACC_W-1:0] v);
    logic signed [ACC_W-1:0] n;
    n = -v;
    return v[ACC_W-1] ? n[MAG_W-1:0] : v[MAG_W-1:0];
  endfunction

  // Reciprocal estimate is the quotient or one below it; one compare fixes it.
  function automatic hcp_pkg::point_t finish_div(
    input logic [ProdW-1:0] prod,
    input logic [MAG_W-1:0] mag,
    input logic             neg
  );
    logic [MAG_W-1:0] q0;
    logic [MAG_W-1:0] qd;
    logic [MAG_W-1:0] rem;
    logic [MAG_W-1:0] qm;
    logic [MAG_W-1:0] res;
    q0  = prod[Sh +: MAG_W];
    qd  = q0 * Div;
    rem = mag - qd;
    qm  = (rem >= Div) ? q0 + 1'b1 : q0;
    res = neg ? -qm : qm;
    return $signed(res[hcp_pkg::POINT_W-1:0]);
  endfunction

  // Evaluator state
  logic            active_q, active_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  fd_t             fdx_q, fdx_d, fdy_q, fdy_d;

  // Stage 1: scaled coordinate
  logic                    s1_v_q, s1_move_q, s1_last_q;
  logic signed [ACC_W-1:0] s1_fx_q, s1_fy_q;

  // Stage 2: reciprocal product
  logic                    s2_v_q, s2_move_q, s2_last_q;
  logic                    s2_negx_q, s2_negy_q;
  logic [MAG_W-1:0]        s2_magx_q, s2_magy_q;
  logic [ProdW-1:0]        s2_prodx_q, s2_prody_q;

  // Output register
  logic                    out_v_q, out_move_q, out_last_q;
  hcp_pkg::point_t         out_x_q, out_y_q;

  logic en, emit, last_emit, pop;

  assign en        = !out_v_q || pt_o.ready;
  assign emit      = en && active_q;
  assign last_emit = emit && (cnt_q == CntLast);
  assign pop       = !stat_i.empty && (!active_q || last_emit);
  assign pop_o     = pop;

  always_comb begin
    active_d = active_q;
    cnt_d    = cnt_q;
    fdx_d    = fdx_q;
    fdy_d    = fdy_q;
    if (pop) begin
      active_d = 1'b1;
      cnt_d    = '0;
      fdx_d    = load_axis(coef_i.x);
      fdy_d    = load_axis(coef_i.y);
    end else if (emit) begin
      cnt_d = cnt_q + 1'b1;
      if (last_emit) begin
        active_d = 1'b0;
      end
      if (cnt_q != '0) begin
        fdx_d = step_axis(fdx_q);
        fdy_d = step_axis(fdy_q);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cnt_q    <= '0;
      s1_v_q   <= 1'b0;
      s2_v_q   <= 1'b0;
      out_v_q  <= 1'b0;
    end else begin
      active_q <= active_d;
      cnt_q    <= cnt_d;
      if (en) begin
        s1_v_q  <= emit;
        s2_v_q  <= s1_v_q;
        out_v_q <= s2_v_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    fdx_q <= fdx_d;
    fdy_q <= fdy_d;
    if (en) begin
      s1_fx_q    <= fdx_q.f;
      s1_fy_q    <= fdy_q.f;
      s1_move_q  <= (cnt_q == '0);
      s1_last_q  <= (cnt_q == CntLast);
      s2_negx_q  <= s1_fx_q[ACC_W-1];
      s2_negy_q  <= s1_fy_q[ACC_W-1];
      s2_magx_q  <= mag_of(s1_fx_q);
      s2_magy_q  <= mag_of(s1_fy_q);
      s2_prodx_q <= ProdW'(mag_of(s1_fx_q)) * ProdW'(Recip);
      s2_prody_q <= ProdW'(mag_of(s1_fy_q)) * ProdW'(Recip);
      s2_move_q  <= s1_move_q;
      s2_last_q  <= s1_last_q;
      out_x_q    <= finish_div(s2_prodx_q, s2_magx_q, s2_negx_q);
      out_y_q    <= finish_div(s2_prody_q, s2_magy_q, s2_negy_q);
      out_move_q <= s2_move_q;
      out_last_q <= s2_last_q;
    end
  end

  assign pt_o.valid      = out_v_q;
  assign pt_o.point_x    = out_x_q;
  assign pt_o.point_y    = out_y_q;
  assign pt_o.is_move    = out_move_q;
  assign pt_o.last_point = out_last_q;

  a_pop_restarts : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop |=> active_q && (cnt_q == '0))
    else $error("segment load did not restart the step counter");

  a_cnt_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    active_q |-> (cnt_q <= CntLast))
    else $error("step counter ran past the last point");

  a_flags_excl : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q |-> !(out_move_q && out_last_q))
    else $error("point flagged as both move-to and last");

  a_move_after_last : assert property (@(posedge clk_i) disable iff (!rst_ni)
    s1_v_q && s1_move_q && $past(s1_v_q) && $past(en) |-> $past(s1_last_q))
    else $error("move-to point did not follow the last point of a segment");

endmodule

### sv/hermite_curve_points.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hermite_curve_points: cubic Hermite spline point generator
// Turns one curve segment (end points and handles) into a move-to point and
// a run of line-to points along the curve.
// ----------------------------------------------------------------------------
// Each segment transfer on seg_i produces Steps+2 point transfers on pt_o:
// first a move-to at the start point (is_move high), then the curve at
// t = k/Steps for k = 0..Steps, the last with last_point high. Tangents are
// the handles minus their end points. Every point is computed exactly as an
// integer scaled by Steps^3 and then truncated toward zero, so the k = 0
// point equals the start point and the k = Steps point equals the end point.
// Throughput is one point per cycle while pt_o accepts every point; the
// evaluator, which walks the cubic by forward differences, sets the rate.
// Segments follow one another with no gap when the next one is queued. A
// queue of QueueDepth prepared segments sits in front of the evaluator, so
// new segments are taken while the current one is still being emitted.
// From a segment transfer to its move-to point, the segment is written into
// the queue, loaded into the evaluator and then passes three pipeline
// stages (scaled value, reciprocal product, corrected quotient in the
// output register). A stall on pt_o holds the whole evaluator pipeline.
// ----------------------------------------------------------------------------
module hermite_curve_points #(
  parameter int Steps      = hcp_pkg::STEPS_DEF,
  parameter int QueueDepth = hcp_pkg::QUEUE_DEPTH
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  hcp_seg_if.sink  seg_i,
  hcp_pt_if.source pt_o
);

  // Prepared segment on its way into the queue.
  hcp_pkg::seg_req_t  push;
  // Fill state of the queue, seen by both the intake and the evaluator.
  hcp_pkg::q_stat_t   q_stat;
  // Head of the queue and the evaluator's request to take it.
  hcp_pkg::seg_coef_t head;
  logic               pop;

  // Intake: forms tangents and polynomial coefficients, accepts a transfer
  // whenever the queue has room.
  hcp_front u_front (
    .seg_i    (seg_i),
    .q_stat_i (q_stat),
    .push_o   (push)
  );

  // Queue decoupling intake from the evaluator.
  hcp_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .pop_i  (pop),
    .stat_o (q_stat),
    .data_o (head)
  );

  // Evaluator: loads a segment as the previous one finishes, emits one point
  // per cycle while pt_o is not stalled, through a three-stage divide pipeline.
  hcp_back #(
    .Steps (Steps)
  ) u_back (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .coef_i (head),
    .stat_i (q_stat),
    .pop_o  (pop),
    .pt_o   (pt_o)
  );

endmodule
